FILE: rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, register and reason codes, and width helpers for the
// ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT   = 16;
  localparam int DET_TOL_WIDTH       = 31;
  localparam int EDGE_TOL_WIDTH      = 17;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int REASON_WIDTH        = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DET_TOL  = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_TOL = 3'd7;

  localparam logic [REASON_WIDTH-1:0] REASON_HIT      = 3'd0;
  localparam logic [REASON_WIDTH-1:0] REASON_PARALLEL = 3'd1;
  localparam logic [REASON_WIDTH-1:0] REASON_U_OUT    = 3'd2;
  localparam logic [REASON_WIDTH-1:0] REASON_V_OUT    = 3'd3;
  localparam logic [REASON_WIDTH-1:0] REASON_BEHIND   = 3'd4;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width of the exact determinant and numerators.
  function automatic int dot_width(input int cw);
    return 3 * cw + 6;
  endfunction

  // Quotient magnitude bits: enough to saturate the output and to keep the
  // edge tests exact for anything the clamp leaves in range.
  function automatic int quo_width(input int cw, input int fb);
    return max_int(cw, max_int(fb, EDGE_TOL_WIDTH) + 3);
  endfunction

  function automatic int cfg_data_width(input int cw);
    return max_int(cw, DET_TOL_WIDTH);
  endfunction

endpackage

FILE: rtl/core/rti_cfg.sv
// ----------------------------------------------------------------------------
// rti_cfg
// Ray and tolerance registers, written through the configuration port.
// ----------------------------------------------------------------------------
module rti_cfg #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [rti_pkg::CFG_INDEX_WIDTH-1:0]           cfg_index,
  input  logic [rti_pkg::cfg_data_width(COORD_WIDTH)-1:0] cfg_data,
  output logic signed [COORD_WIDTH-1:0]                 org [3],
  output logic signed [COORD_WIDTH-1:0]                 dir [3],
  output logic [rti_pkg::DET_TOL_WIDTH-1:0]             det_tol,
  output logic [rti_pkg::EDGE_TOL_WIDTH-1:0]            edge_tol
);
  import rti_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0]   <= '0;
      org[1]   <= '0;
      org[2]   <= '0;
      dir[0]   <= '0;
      dir[1]   <= '0;
      dir[2]   <= COORD_WIDTH'(1) << FRAC_BITS;
      det_tol  <= '0;
      edge_tol <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org[0]   <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: org[1]   <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: org[2]   <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_X:    dir[0]   <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Y:    dir[1]   <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Z:    dir[2]   <= cfg_data[COORD_WIDTH-1:0];
        REG_DET_TOL:  det_tol  <= cfg_data[DET_TOL_WIDTH-1:0];
        REG_EDGE_TOL: edge_tol <= cfg_data[EDGE_TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/rti_geom.sv
// ----------------------------------------------------------------------------
// rti_geom
// Six-stage exact datapath: edges, cross products, and the four dot products
// that give the determinant and the numerators of u, v and t.
// ----------------------------------------------------------------------------
module rti_geom #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          advance,
  input  logic signed [COORD_WIDTH-1:0]                 va [3],
  input  logic signed [COORD_WIDTH-1:0]                 vb [3],
  input  logic signed [COORD_WIDTH-1:0]                 vc [3],
  input  logic signed [COORD_WIDTH-1:0]                 org [3],
  input  logic signed [COORD_WIDTH-1:0]                 dir [3],
  output logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0] det,
  output logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0] num_u,
  output logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0] num_v,
  output logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0] num_t
);
  import rti_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int CW = 2 * COORD_WIDTH + 3;
  localparam int LW = 2 * COORD_WIDTH + 2;
  localparam int HW = 2 * COORD_WIDTH + 4;
  localparam int DW = dot_width(COORD_WIDTH);

  logic signed [EW-1:0] s0_eab [3], s0_eac [3], s0_tv [3];
  logic signed [EW-1:0] s1_eab [3], s1_eac [3], s1_tv [3];
  logic signed [EW-1:0] s2_eab [3], s2_eac [3], s2_tv [3];
  logic signed [PW-1:0] s1_pd [6], s1_qd [6];
  logic signed [CW-1:0] s2_pv [3], s2_qv [3];
  logic signed [EW-1:0] opa [4][3];
  logic signed [CW-1:0] opc [4][3];
  logic signed [COORD_WIDTH:0]   op_lo [4][3];
  logic signed [COORD_WIDTH+2:0] op_hi [4][3];
  logic signed [LW-1:0] s3_plo [4][3];
  logic signed [HW-1:0] s3_phi [4][3];
  logic signed [DW-1:0] s4_term [4][3];
  logic signed [DW-1:0] s5_sum [4];

  // Stage 0: edge vectors and origin offset.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s0_eab[i] <= EW'(vb[i]) - EW'(va[i]);
        s0_eac[i] <= EW'(vc[i]) - EW'(va[i]);
        s0_tv[i]  <= EW'(org[i]) - EW'(va[i]);
      end
    end
  end

  // Stage 1: products for P = dir x eac and Q = tvec x eab.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pd[0] <= PW'(dir[1]) * PW'(s0_eac[2]);
      s1_pd[1] <= PW'(dir[2]) * PW'(s0_eac[1]);
      s1_pd[2] <= PW'(dir[2]) * PW'(s0_eac[0]);
      s1_pd[3] <= PW'(dir[0]) * PW'(s0_eac[2]);
      s1_pd[4] <= PW'(dir[0]) * PW'(s0_eac[1]);
      s1_pd[5] <= PW'(dir[1]) * PW'(s0_eac[0]);
      s1_qd[0] <= PW'(s0_tv[1]) * PW'(s0_eab[2]);
      s1_qd[1] <= PW'(s0_tv[2]) * PW'(s0_eab[1]);
      s1_qd[2] <= PW'(s0_tv[2]) * PW'(s0_eab[0]);
      s1_qd[3] <= PW'(s0_tv[0]) * PW'(s0_eab[2]);
      s1_qd[4] <= PW'(s0_tv[0]) * PW'(s0_eab[1]);
      s1_qd[5] <= PW'(s0_tv[1]) * PW'(s0_eab[0]);
      s1_eab   <= s0_eab;
      s1_eac   <= s0_eac;
      s1_tv    <= s0_tv;
    end
  end

  // Stage 2: cross product differences.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s2_pv[i] <= CW'(s1_pd[2*i]) - CW'(s1_pd[2*i+1]);
        s2_qv[i] <= CW'(s1_qd[2*i]) - CW'(s1_qd[2*i+1]);
      end
      s2_eab <= s1_eab;
      s2_eac <= s1_eac;
      s2_tv  <= s1_tv;
    end
  end

  // The wide cross components are split into a low unsigned half and a
  // signed high half so that each multiplier stays near 33 by 35 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[0][i] = s2_eab[i];
      opc[0][i] = s2_pv[i];
      opa[1][i] = s2_tv[i];
      opc[1][i] = s2_pv[i];
      opa[2][i] = EW'(dir[i]);
      opc[2][i] = s2_qv[i];
      opa[3][i] = s2_eac[i];
      opc[3][i] = s2_qv[i];
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        op_lo[k][i] = $signed({1'b0, opc[k][i][COORD_WIDTH-1:0]});
        op_hi[k][i] = $signed(opc[k][i][CW-1:COORD_WIDTH]);
      end
    end
  end

  // Stage 3: partial products of the dot products.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          s3_plo[k][i] <= LW'(opa[k][i]) * LW'(op_lo[k][i]);
          s3_phi[k][i] <= HW'(opa[k][i]) * HW'(op_hi[k][i]);
        end
      end
    end
  end

  // Stage 4: recombine the halves of each term.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          s4_term[k][i] <= (DW'(s3_phi[k][i]) <<< COORD_WIDTH) + DW'(s3_plo[k][i]);
        end
      end
    end
  end

  // Stage 5: sum the three terms of each dot product.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        s5_sum[k] <= s4_term[k][0] + s4_term[k][1] + s4_term[k][2];
      end
    end
  end

  assign det   = s5_sum[0];
  assign num_u = s5_sum[1];
  assign num_v = s5_sum[2];
  assign num_t = s5_sum[3];

endmodule

FILE: rtl/core/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring division of the three scaled numerators by the shared
// determinant, one quotient bit per stage, with the parallel test.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                               clk,
  input  logic                                               advance,
  input  logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0]  det,
  input  logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0]  num_u,
  input  logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0]  num_v,
  input  logic signed [rti_pkg::dot_width(COORD_WIDTH)-1:0]  num_t,
  input  logic [rti_pkg::DET_TOL_WIDTH-1:0]                  det_tol,
  output logic                                               parallel,
  output logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_u,
  output logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_v,
  output logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_t
);
  import rti_pkg::*;

  localparam int DW = dot_width(COORD_WIDTH);
  localparam int QW = quo_width(COORD_WIDTH, FRAC_BITS);
  localparam int NW = DW + FRAC_BITS;
  localparam int XW = NW + QW;

  logic signed [DW-1:0] num_in [3];
  logic [DW-1:0]        det_abs;
  logic [DW-1:0]        num_abs [3];

  logic [DW-1:0] a_dmag;
  logic [DW-1:0] a_nmag [3];
  logic [2:0]    a_neg;
  logic          a_par;

  logic [NW-1:0] rem [QW][3];
  logic [DW-1:0] dm [QW];
  logic [QW-1:0] quo [QW+1][3];
  logic [2:0]    sg [QW+1];
  logic [2:0]    of [QW+1];
  logic          pr [QW+1];

  logic [XW-1:0] dsh [QW];
  logic [2:0]    take [QW];
  logic [XW-1:0] diff [QW-1][3];

  logic [QW-1:0]      mag [3];
  logic signed [QW:0] sval [3];

  assign num_in[0] = num_u;
  assign num_in[1] = num_v;
  assign num_in[2] = num_t;

  always_comb begin
    det_abs = det[DW-1] ? DW'(-det) : DW'(det);
    for (int k = 0; k < 3; k++) begin
      num_abs[k] = num_in[k][DW-1] ? DW'(-num_in[k]) : DW'(num_in[k]);
    end
  end

  // Magnitudes, quotient signs and the parallel test.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_dmag <= det_abs;
      a_par  <= det_abs <= DW'(det_tol);
      for (int k = 0; k < 3; k++) begin
        a_nmag[k] <= num_abs[k];
        a_neg[k]  <= num_in[k][DW-1] ^ det[DW-1];
      end
    end
  end

  // Scale by the fraction bits and flag quotients too large for QW bits.
  always_ff @(posedge clk) begin
    if (advance) begin
      dm[0] <= a_dmag;
      pr[0] <= a_par;
      sg[0] <= a_neg;
      for (int k = 0; k < 3; k++) begin
        rem[0][k]  <= {a_nmag[k], {FRAC_BITS{1'b0}}};
        quo[0][k]  <= '0;
        of[0][k]   <= XW'({a_nmag[k], {FRAC_BITS{1'b0}}}) >= XW'({a_dmag, {QW{1'b0}}});
      end
    end
  end

  // Stage j decides quotient bit QW-1-j. The last stage only needs the
  // compare, since its remainder is never kept.
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dsh[j] = XW'(dm[j]) << (QW - 1 - j);
      for (int k = 0; k < 3; k++) begin
        take[j][k] = XW'(rem[j][k]) >= dsh[j];
      end
    end
    for (int j = 0; j < QW - 1; j++) begin
      for (int k = 0; k < 3; k++) begin
        diff[j][k] = XW'(rem[j][k]) - dsh[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < QW; j++) begin
        pr[j+1] <= pr[j];
        sg[j+1] <= sg[j];
        of[j+1] <= of[j];
        for (int k = 0; k < 3; k++) begin
          quo[j+1][k] <= quo[j][k] | (QW'(take[j][k]) << (QW - 1 - j));
        end
      end
      for (int j = 0; j < QW - 1; j++) begin
        dm[j+1] <= dm[j];
        for (int k = 0; k < 3; k++) begin
          rem[j+1][k] <= take[j][k] ? diff[j][k][NW-1:0] : rem[j][k];
        end
      end
    end
  end

  // Clamp on overflow, then apply the sign.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = of[QW][k] ? '1 : quo[QW][k];
      sval[k] = $signed({1'b0, mag[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      parallel <= pr[QW];
      quo_u    <= sg[QW][0] ? -sval[0] : sval[0];
      quo_v    <= sg[QW][1] ? -sval[1] : sval[1];
      quo_t    <= sg[QW][2] ? -sval[2] : sval[2];
    end
  end

endmodule

FILE: rtl/core/rti_out.sv
// ----------------------------------------------------------------------------
// rti_out
// Edge and distance tests, saturation, the result register and a one-entry
// skid buffer toward the result channel.
// ----------------------------------------------------------------------------
module rti_out #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 advance,
  input  logic                                                 last_valid,
  input  logic                                                 parallel,
  input  logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_u,
  input  logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_v,
  input  logic signed [rti_pkg::quo_width(COORD_WIDTH, FRAC_BITS):0] quo_t,
  input  logic [rti_pkg::EDGE_TOL_WIDTH-1:0]                   edge_tol,
  input  logic                                                 out_ready,
  output logic                                                 hold,
  output logic                                                 out_valid,
  output logic                                                 hit,
  output logic [rti_pkg::REASON_WIDTH-1:0]                     miss_reason,
  output logic signed [COORD_WIDTH-1:0]                        distance,
  output logic signed [COORD_WIDTH-1:0]                        bary_u,
  output logic signed [COORD_WIDTH-1:0]                        bary_v
);
  import rti_pkg::*;

  localparam int QW = quo_width(COORD_WIDTH, FRAC_BITS);
  localparam int SW = QW + 1;
  localparam int TW = SW + 1;
  localparam logic signed [SW-1:0] SAT_HI = $signed(SW'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] x);
    logic [COORD_WIDTH-1:0] r;
    if (x > SAT_HI) r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    else if (x < SAT_LO) r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    else r = x[COORD_WIDTH-1:0];
    return r;
  endfunction

  logic signed [TW-1:0] u_e, v_e, uv_e, tol_s, lo, hi;
  logic                 hit_n;
  logic [REASON_WIDTH-1:0] reason_n;
  logic [COORD_WIDTH-1:0] u_n, v_n, t_n;

  logic                    r_hit, k_hit;
  logic [REASON_WIDTH-1:0] r_reason, k_reason;
  logic [COORD_WIDTH-1:0]  r_dist, r_u, r_v, k_dist, k_u, k_v;
  logic                    skid_full;

  always_comb begin
    u_e   = TW'(quo_u);
    v_e   = TW'(quo_v);
    uv_e  = u_e + v_e;
    tol_s = $signed(TW'(edge_tol));
    lo    = -tol_s;
    hi    = ($signed(TW'(1)) <<< FRAC_BITS) + tol_s;

    hit_n    = 1'b0;
    reason_n = REASON_HIT;
    u_n      = sat(quo_u);
    v_n      = '0;
    t_n      = '0;
    priority if (parallel) begin
      reason_n = REASON_PARALLEL;
      u_n      = '0;
    end else if (u_e < lo || u_e > hi) begin
      reason_n = REASON_U_OUT;
    end else if (v_e < lo || uv_e > hi) begin
      reason_n = REASON_V_OUT;
      v_n      = sat(quo_v);
    end else if (quo_t <= 0) begin
      reason_n = REASON_BEHIND;
      v_n      = sat(quo_v);
    end else begin
      hit_n = 1'b1;
      v_n   = sat(quo_v);
      t_n   = sat(quo_t);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_hit    <= hit_n;
      r_reason <= reason_n;
      r_dist   <= t_n;
      r_u      <= u_n;
      r_v      <= v_n;
    end
  end

  // A result that cannot leave moves into the skid entry, so the pipeline
  // is not stopped until that entry is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full && last_valid && !out_ready) begin
      skid_full <= 1'b1;
    end else if (skid_full && out_ready) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      k_hit    <= r_hit;
      k_reason <= r_reason;
      k_dist   <= r_dist;
      k_u      <= r_u;
      k_v      <= r_v;
    end
  end

  assign hold        = skid_full;
  assign out_valid   = skid_full || last_valid;
  assign hit         = skid_full ? k_hit    : r_hit;
  assign miss_reason = skid_full ? k_reason : r_reason;
  assign distance    = skid_full ? k_dist   : r_dist;
  assign bary_u      = skid_full ? k_u      : r_u;
  assign bary_v      = skid_full ? k_v      : r_v;

endmodule

FILE: rtl/core/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Streams triangles against a configured ray in signed fixed point and
// reports hit, miss reason, distance and barycentric coordinates.
//
//   Channel  | Handshake              | Contents
//   ---------+------------------------+-----------------------------------
//   input    | in_valid / in_ready    | a_x .. c_z, one triangle
//   result   | out_valid / out_ready  | hit, miss_reason, distance, bary_u/v
//   config   | cfg_we                 | cfg_index, cfg_data
//
// One triangle enters per cycle while in_ready is high. QW is the quotient
// width (32 at the default widths); the divider resolves one quotient bit per
// stage. Reset clears the valid bits, the skid entry and the configuration
// registers to their defaults. A stalled result moves into a one-entry skid
// buffer as the pipeline advances; in_ready drops only while that entry is
// full, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic [rti_pkg::CFG_INDEX_WIDTH-1:0]             cfg_index,
  input  logic [rti_pkg::cfg_data_width(COORD_WIDTH)-1:0] cfg_data,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]                   a_x,
  input  logic signed [COORD_WIDTH-1:0]                   a_y,
  input  logic signed [COORD_WIDTH-1:0]                   a_z,
  input  logic signed [COORD_WIDTH-1:0]                   b_x,
  input  logic signed [COORD_WIDTH-1:0]                   b_y,
  input  logic signed [COORD_WIDTH-1:0]                   b_z,
  input  logic signed [COORD_WIDTH-1:0]                   c_x,
  input  logic signed [COORD_WIDTH-1:0]                   c_y,
  input  logic signed [COORD_WIDTH-1:0]                   c_z,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic                                            hit,
  output logic [rti_pkg::REASON_WIDTH-1:0]                miss_reason,
  output logic signed [COORD_WIDTH-1:0]                   distance,
  output logic signed [COORD_WIDTH-1:0]                   bary_u,
  output logic signed [COORD_WIDTH-1:0]                   bary_v
);
  import rti_pkg::*;

  localparam int DW = dot_width(COORD_WIDTH);
  localparam int QW = quo_width(COORD_WIDTH, FRAC_BITS);
  localparam int NS = QW + 10;

  logic signed [COORD_WIDTH-1:0] va [3], vb [3], vc [3];
  logic signed [COORD_WIDTH-1:0] org [3], dir [3];
  logic [DET_TOL_WIDTH-1:0]      det_tol;
  logic [EDGE_TOL_WIDTH-1:0]     edge_tol;
  logic signed [DW-1:0]          det, num_u, num_v, num_t;
  logic                          parallel;
  logic signed [QW:0]            quo_u, quo_v, quo_t;
  logic                          advance, hold;
  logic [NS-1:0]                 stage_valid;

  assign va[0] = a_x;
  assign va[1] = a_y;
  assign va[2] = a_z;
  assign vb[0] = b_x;
  assign vb[1] = b_y;
  assign vb[2] = b_z;
  assign vc[0] = c_x;
  assign vc[1] = c_y;
  assign vc[2] = c_z;

  assign advance  = !hold;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[NS-2:0], in_valid};
    end
  end

  rti_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .org       (org),
    .dir       (dir),
    .det_tol   (det_tol),
    .edge_tol  (edge_tol)
  );

  rti_geom #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_geom (
    .clk     (clk),
    .advance (advance),
    .va      (va),
    .vb      (vb),
    .vc      (vc),
    .org     (org),
    .dir     (dir),
    .det     (det),
    .num_u   (num_u),
    .num_v   (num_v),
    .num_t   (num_t)
  );

  rti_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .advance  (advance),
    .det      (det),
    .num_u    (num_u),
    .num_v    (num_v),
    .num_t    (num_t),
    .det_tol  (det_tol),
    .parallel (parallel),
    .quo_u    (quo_u),
    .quo_v    (quo_v),
    .quo_t    (quo_t)
  );

  rti_out #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .last_valid  (stage_valid[NS-1]),
    .parallel    (parallel),
    .quo_u       (quo_u),
    .quo_v       (quo_v),
    .quo_t       (quo_t),
    .edge_tol    (edge_tol),
    .out_ready   (out_ready),
    .hold        (hold),
    .out_valid   (out_valid),
    .hit         (hit),
    .miss_reason (miss_reason),
    .distance    (distance),
    .bary_u      (bary_u),
    .bary_v      (bary_v)
  );

  a_hit_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> miss_reason == REASON_HIT)
    else $error("hit flag disagrees with reason code");

  a_hit_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !distance[COORD_WIDTH-1] && distance != '0)
    else $error("hit with non-positive distance");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && miss_reason == REASON_PARALLEL |->
      distance == '0 && bary_u == '0 && bary_v == '0)
    else $error("parallel result carries nonzero fields");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid[0])
    else $error("accepted transaction did not enter the pipeline");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection testbench
// Streams triangles through the intersection pipeline under several ray and
// tolerance settings, with random gaps and stalls on both channels, and checks
// every result against hand-written values or an exact wide-integer model.
// ----------------------------------------------------------------------------
module tb_top;
  import rti_pkg::*;

  localparam int CW = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE = 60;
  localparam int PHASE_ITEMS = 175;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } facet_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       reason;
    coord_t           t_dist;
    coord_t           u;
    coord_t           v;
  } hit_res_t;

  typedef struct {
    facet_t   f;
    bit       typed;
    hit_res_t r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  coord_t a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0, c_x = 0, c_y = 0, c_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic hit;
  logic [REASON_WIDTH-1:0] miss_reason;
  coord_t distance, bary_u, bary_v;

  ray_triangle_intersect dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Ray and tolerance as the block should hold them.
  coord_t ray_org[3];
  coord_t ray_dir[3];
  logic [DET_TOL_WIDTH-1:0] det_tol;
  logic [EDGE_TOL_WIDTH-1:0] edge_tol;

  hit_res_t expected_hits[$];
  int errors = 0;
  bit hold_req = 0;
  bit tx_idle = 1;
  bit rx_idle = 1;
  int quiet_cycles = 0;

  function automatic wide_t sat_coord(wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (CW - 1));
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Exact Moller-Trumbore in wide integers; quotients truncate toward zero.
  function automatic hit_res_t intersect_facet(facet_t f);
    hit_res_t r;
    wide_t va[3], vb[3], vc[3], o[3], d[3];
    wide_t e1[3], e2[3], tv[3], p[3], q[3];
    wide_t det, mag, tol, lo, hi, uq, vq, tq, one;
    va[0] = wide_t'(f.ax); va[1] = wide_t'(f.ay); va[2] = wide_t'(f.az);
    vb[0] = wide_t'(f.bx); vb[1] = wide_t'(f.by); vb[2] = wide_t'(f.bz);
    vc[0] = wide_t'(f.cx); vc[1] = wide_t'(f.cy); vc[2] = wide_t'(f.cz);
    for (int i = 0; i < 3; i++) begin
      o[i] = wide_t'(ray_org[i]);
      d[i] = wide_t'(ray_dir[i]);
      e1[i] = vb[i] - va[i];
      e2[i] = vc[i] - va[i];
      tv[i] = o[i] - va[i];
    end
    r = '0;
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    mag = (det < 0) ? -det : det;
    tol = wide_t'(det_tol);
    if (mag <= tol) begin
      r.reason = REASON_PARALLEL;
      return r;
    end
    one = wide_t'(1) <<< FRAC_BITS_DEFAULT;
    lo = wide_t'(edge_tol);
    lo = -lo;
    hi = wide_t'(edge_tol);
    hi = hi + one;
    uq = ((tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2]) * one) / det;
    r.u = coord_t'(sat_coord(uq));
    if (uq < lo || uq > hi) begin
      r.reason = REASON_U_OUT;
      return r;
    end
    q[0] = tv[1] * e1[2] - tv[2] * e1[1];
    q[1] = tv[2] * e1[0] - tv[0] * e1[2];
    q[2] = tv[0] * e1[1] - tv[1] * e1[0];
    vq = ((d[0] * q[0] + d[1] * q[1] + d[2] * q[2]) * one) / det;
    r.v = coord_t'(sat_coord(vq));
    if (vq < lo || uq + vq > hi) begin
      r.reason = REASON_V_OUT;
      return r;
    end
    tq = ((e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2]) * one) / det;
    if (tq <= wide_t'(0)) begin
      r.reason = REASON_BEHIND;
      return r;
    end
    r.hit = 1'b1;
    r.reason = REASON_HIT;
    r.t_dist = coord_t'(sat_coord(tq));
    return r;
  endfunction

  task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    unique case (idx)
      REG_ORIGIN_X: ray_org[0] = data;
      REG_ORIGIN_Y: ray_org[1] = data;
      REG_ORIGIN_Z: ray_org[2] = data;
      REG_DIR_X:    ray_dir[0] = data;
      REG_DIR_Y:    ray_dir[1] = data;
      REG_DIR_Z:    ray_dir[2] = data;
      REG_DET_TOL:  det_tol = data[DET_TOL_WIDTH-1:0];
      REG_EDGE_TOL: edge_tol = data[EDGE_TOL_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                          coord_t dz, logic [CW-1:0] dtol, logic [CW-1:0] etol);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_DET_TOL, dtol);
    write_reg(REG_EDGE_TOL, etol);
    cfg_we <= 0;
  endtask

  // Waits for every outstanding result, then for the pipeline to go quiet.
  task automatic drain();
    if (in_valid) in_valid <= 0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(facet_t f, bit typed, hit_res_t want);
    int gap;
    hit_res_t exp_res;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= f;
    do @(posedge clk); while (!in_ready);
    exp_res = typed ? want : intersect_facet(f);
    expected_hits = {expected_hits, exp_res};
    if ($urandom_range(0, 49) == 0) tx_idle = !tx_idle;
  endtask

  function automatic coord_t near_coord();
    return coord_t'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  function automatic facet_t rand_facet();
    facet_t f;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      f = {near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
           near_coord(), near_coord(), near_coord(), near_coord()};
    end else begin
      f = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
    end
    // A collapsed edge makes the determinant zero.
    if (kind == 6) {f.bx, f.by, f.bz} = {f.ax, f.ay, f.az};
    return f;
  endfunction

  function automatic row_t mk_row(facet_t f, bit typed, hit_res_t r);
    row_t x;
    x.f = f;
    x.typed = typed;
    x.r = r;
    return x;
  endfunction

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    int n;
    hit_res_t want;
    @(negedge rst);
    forever begin
      n = rx_idle ? $urandom_range(0, 13) : 0;
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end else if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      if (expected_hits.size() == 0) begin
        report("unexpected transaction", CW'({hit, miss_reason}), '0);
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want.hit) report("hit", CW'(hit), CW'(want.hit));
        if (miss_reason !== want.reason)
          report("miss_reason", CW'(miss_reason), CW'(want.reason));
        if (distance !== want.t_dist) report("distance", distance, want.t_dist);
        if (bary_u !== want.u) report("bary_u", bary_u, want.u);
        if (bary_v !== want.v) report("bary_v", bary_v, want.v);
      end
      if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t CMAX = 32'sh7fff_ffff;
    localparam coord_t CMIN = 32'sh8000_0000;
    row_t rows[$];
    hit_res_t none;
    none = '0;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, ONE};
    det_tol = 0;
    edge_tol = 0;

    // Reset ray runs from the origin along +z.
    rows = {rows, mk_row('0, 1, '{0, REASON_PARALLEL, 0, 0, 0})};
    rows = {rows, mk_row({32'sd0, 32'sd0, ONE, ONE, 32'sd0, ONE, 32'sd0, ONE, ONE}, 1,
                         '{1, REASON_HIT, ONE, 0, 0})};
    rows = {rows, mk_row({32'sd0, 32'sd0, -ONE, ONE, 32'sd0, -ONE, 32'sd0, ONE, -ONE}, 1,
                         '{0, REASON_BEHIND, 0, 0, 0})};
    rows = {rows, mk_row({ONE, 32'sd0, ONE, 2 * ONE, 32'sd0, ONE, ONE, ONE, ONE}, 1,
                         '{0, REASON_U_OUT, 0, -ONE, 0})};
    rows = {rows, mk_row({32'sd0, ONE, ONE, ONE, ONE, ONE, 32'sd0, 2 * ONE, ONE}, 1,
                         '{0, REASON_V_OUT, 0, 0, -ONE})};
    rows = {rows, mk_row({9{CMAX}}, 1, '{0, REASON_PARALLEL, 0, 0, 0})};
    rows = {rows, mk_row({9{CMIN}}, 1, '{0, REASON_PARALLEL, 0, 0, 0})};
    // Extreme coordinate mixes and other cases; these go through the model.
    rows = {rows, mk_row({CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX}, 0, none)};
    rows = {rows, mk_row({CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN}, 0, none)};
    rows = {rows, mk_row({32'sd1, 32'sd0, 32'sd1, CMAX, 32'sd0, 32'sd1, 32'sd0, CMAX,
                          32'sd1}, 0, none)};
    rows = {rows, mk_row({-ONE, -ONE, ONE, ONE, -ONE, 2 * ONE, -ONE, ONE, 3 * ONE}, 0,
                         none)};
    rows = {rows, mk_row({-ONE, -ONE, 32'sd1, ONE, -ONE, 32'sd1, -ONE, ONE, 32'sd1}, 0,
                         none)};

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].f, rows[i].typed, rows[i].r);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: load_ray(ONE / 4, -ONE / 2, -3 * ONE, ONE / 2, ONE / 4, ONE,
                    32'h8000_0064, 32'hfffe_1000);
        2: load_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 32'h7fff_ffff, 32'h0001_0000);
        3: load_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 32'h0, 32'h0);
        4: load_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        default: load_ray(0, 0, -2 * ONE, -ONE / 8, ONE / 8, ONE,
                          32'h7fff_ffff, 32'h0001_0000);
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 1 && k == 20) hold_req = 1;
        send(rand_facet(), 0, none);
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
